// File: hdl/rtpst_pkg.sv
package rtpst_pkg;

  localparam int EXT_SEQ_BITS = 48;
  localparam int CLK_W = 18;
  localparam int DIV_NW = 32 + 8;
  localparam int DIV_DW = EXT_SEQ_BITS;
  localparam int DIV_CW = $clog2(DIV_NW + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE = 2'd2;

  localparam logic [14:0] DEF_REORDER = 15'd450;
  localparam logic [15:0] DEF_IDLE_MS = 16'd8000;
  localparam logic [31:0] MAX_TRANSIT_DIFF = 32'd450000;
  localparam logic [22:0] LOST_CAP = 23'h7FFFFF;
  localparam logic [9:0]  MS_PER_S = 10'd1000;
  // ceil(2^38 / 1000), exact floor division for any 32-bit dividend
  localparam logic [28:0] RECIP_1000 = 29'h10624DD3;
  localparam int          RECIP_SHIFT = 38;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_JIT,
    ST_RSTART, ST_RWAIT, ST_FRAC, ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic div_start;
    logic jit_upd;
    logic frac_upd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_jit;
    logic emit;
    logic need_frac;
    logic div_busy;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: hdl/rtpst_if.sv
interface rtpst_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] seq_num;
  logic [31:0] rtp_timestamp;
  logic [17:0] clock_rate_hz;
  logic [31:0] now_ms;
  modport source (output valid, req_type, seq_num, rtp_timestamp, clock_rate_hz, now_ms,
                  input ready);
  modport sink (input valid, req_type, seq_num, rtp_timestamp, clock_rate_hz, now_ms,
                output ready);
endinterface

interface rtpst_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] report_ssrc;
  logic [7:0]  fraction_lost;
  logic [22:0] cumulative_lost;
  logic [31:0] ext_highest_seq;
  logic [27:0] jitter;
  modport source (output valid, report_ssrc, fraction_lost, cumulative_lost,
                  ext_highest_seq, jitter, input ready);
  modport sink (input valid, report_ssrc, fraction_lost, cumulative_lost,
                ext_highest_seq, jitter, output ready);
endinterface

// File: hdl/rtpst_div.sv
module rtpst_div
  import rtpst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic [DIV_NW-1:0] quotient,
  output logic              busy,
  output logic              done
);

  logic [DIV_DW-1:0] rem;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   trial;

  // one quotient bit a cycle, restoring
  assign trial = {rem, quotient[DIV_NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem      <= DIV_DW'(trial - {1'b0, divisor});
        quotient <= {quotient[DIV_NW-2:0], 1'b1};
      end else begin
        rem      <= trial[DIV_DW-1:0];
        quotient <= {quotient[DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/rtpst_ctrl.sv
module rtpst_ctrl
  import rtpst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (sts.need_jit) state_next = ST_MUL1;
        else if (sts.emit && sts.need_frac) state_next = ST_RSTART;
        else if (sts.emit) state_next = ST_EMIT;
        else state_next = ST_IDLE;
      end
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_MUL4;
      ST_MUL4:   state_next = ST_JIT;
      ST_JIT:    state_next = ST_IDLE;
      ST_RSTART: state_next = ST_RWAIT;
      ST_RWAIT:  if (sts.div_done) state_next = ST_FRAC;
      ST_FRAC:   state_next = ST_EMIT;
      ST_EMIT:   if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EXEC:   cmd.exec = 1'b1;
      ST_MUL1:   cmd.mul1 = 1'b1;
      ST_MUL2:   cmd.mul2 = 1'b1;
      ST_MUL3:   cmd.mul3 = 1'b1;
      ST_MUL4:   cmd.mul4 = 1'b1;
      ST_JIT:    cmd.jit_upd = 1'b1;
      ST_RSTART: cmd.div_start = 1'b1;
      ST_FRAC:   cmd.frac_upd = 1'b1;
      ST_EMIT:   cmd.out_load = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy) else $error("divider started while busy");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free) else $error("result loaded over pending result");
  a_frac_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RWAIT && sts.div_done) |=> cmd.frac_upd)
    else $error("fraction update missed");
  a_jit_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL4) |=> cmd.jit_upd) else $error("jitter update missed");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.div_busy) else $error("input taken during division");

endmodule

// File: hdl/rtpst_dp.sv
module rtpst_dp
  import rtpst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rtpst_in_if.sink              pkt_in,
  rtpst_out_if.source           rpt_out,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts
);

  localparam int XW = EXT_SEQ_BITS;

  logic [31:0] stream_id;
  logic [14:0] reorder_threshold;
  logic [15:0] idle_timeout_ms;

  logic          seen_any;
  logic [1:0]    packet_count;
  logic [XW-1:0] highest_ext_seq;
  logic [XW-1:0] unwrap_base;
  logic          jump_pending;
  logic [15:0]   jump_seq;
  logic [31:0]   loss_total;
  logic [31:0]   loss_offset;
  logic [31:0]   prev_timestamp;
  logic [31:0]   prev_arrival_ms;
  logic [31:0]   jitter_q4;
  logic [XW-1:0] report_seq_mark;
  logic [31:0]   report_loss_mark;

  // latched request
  logic        req_type;
  logic [15:0] seq_num;
  logic [31:0] rtp_timestamp;
  logic [CLK_W-1:0] clock_rate_hz;
  logic [31:0] now_ms;

  // jitter work registers
  logic        dms_neg;
  logic [31:0] dms_mag;
  logic [31:0] ts_diff;
  logic [22:0] mag_q;
  logic [9:0]  mag_r;
  logic [31:0] rtp_hi;
  logic [27:0] rtp_lo_num;
  logic [18:0] rtp_lo;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;

  logic [DIV_NW-1:0] quotient;
  logic div_busy, div_done;

  // result staging
  logic        out_valid;
  logic [7:0]  frac;
  logic [22:0] lost_q;
  logic [31:0] ssrc_q;
  logic [31:0] ehs_q;
  logic [27:0] jit_q;

  rtpst_div u_div (
    .clk, .rst,
    .start(cmd.div_start),
    .dividend(div_num),
    .divisor(div_den),
    .quotient,
    .busy(div_busy),
    .done(div_done)
  );

  // sequence number extension
  logic [15:0]   low16, d16, up16, dn16;
  logic          ahead;
  logic [XW-1:0] cand, s_ext;
  always_comb begin
    low16 = unwrap_base[15:0];
    d16   = seq_num - low16;
    up16  = seq_num - low16;
    dn16  = low16 - seq_num;
    ahead = (d16 != 16'd0) && ((d16 < 16'h8000) || (d16 == 16'h8000 && seq_num > low16));
    cand  = unwrap_base + XW'(up16) - XW'(17'h10000);
    if (!seen_any) s_ext = XW'(seq_num);
    else if (ahead) s_ext = unwrap_base + XW'(d16);
    else if (seq_num > low16) s_ext = cand[XW-1] ? unwrap_base + XW'(up16) : cand;
    else s_ext = unwrap_base - XW'(dn16);
  end

  // sequence check and loss accounting
  logic [XW-1:0] hh, seq_gap, gap_abs;
  logic          jp_match, big_jump, in_order;
  logic [1:0]    pc_inc;
  logic [31:0]   loss_dec;
  always_comb begin
    pc_inc   = (packet_count == 2'd3) ? packet_count : packet_count + 2'd1;
    loss_dec = loss_total - 32'd1;
    jp_match = seen_any && jump_pending && (seq_num == jump_seq + 16'd1);
    seq_gap  = s_ext - highest_ext_seq;
    gap_abs  = seq_gap[XW-1] ? XW'(0) - seq_gap : seq_gap;
    big_jump = seen_any && !jp_match && (gap_abs > XW'(reorder_threshold));
    if (!seen_any) hh = s_ext - XW'(1);
    else if (jp_match) hh = s_ext - XW'(2);
    else hh = highest_ext_seq;
    in_order = !seen_any || jp_match ||
               (!big_jump && ($signed(s_ext) > $signed(highest_ext_seq)));
  end

  // report checks
  logic [31:0]   age, rloss, lost_sum;
  logic [XW-1:0] expect_cnt;
  logic          emit;
  always_comb begin
    age        = now_ms - prev_arrival_ms;
    emit       = seen_any && !(!age[31] && age > 32'(idle_timeout_ms));
    expect_cnt = highest_ext_seq - report_seq_mark + XW'(1);
    rloss      = loss_total - report_loss_mark;
    lost_sum   = loss_total + loss_offset;
  end

  // mag = q * 1000 + r, so mag * rate / 1000 = q * rate + r * rate / 1000
  logic [60:0] mag_prod;
  logic [31:0] mag_back, mag_rem;
  logic [40:0] hi_prod;
  logic [27:0] lo_num;
  logic [56:0] lo_prod;
  always_comb begin
    mag_prod = dms_mag * RECIP_1000;
    mag_back = 32'(mag_q) * 32'(MS_PER_S);
    mag_rem  = dms_mag - mag_back;
    hi_prod  = mag_q * clock_rate_hz;
    lo_num   = mag_r * clock_rate_hz;
    lo_prod  = rtp_lo_num * RECIP_1000;
  end

  // jitter update
  logic [31:0] rtp_mag, rtp_d, tr, tm;
  logic signed [36:0] jd, jstep;
  always_comb begin
    rtp_mag = rtp_hi + 32'(rtp_lo);
    rtp_d = dms_neg ? 32'd0 - rtp_mag : rtp_mag;
    tr    = rtp_d - ts_diff;
    tm    = tr[31] ? 32'd0 - tr : tr;
    jd    = $signed({1'b0, tm, 4'd0}) - $signed({5'd0, jitter_q4}) + 37'sd8;
    jstep = jd >>> 4;
  end

  always_comb begin
    sts.need_jit  = !req_type && in_order && !big_jump &&
                    (rtp_timestamp != prev_timestamp) && (pc_inc > 2'd1);
    sts.emit      = req_type && emit;
    sts.need_frac = (expect_cnt != '0) && !expect_cnt[XW-1] && (rloss != 32'd0) && !rloss[31];
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || rpt_out.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_id <= '0;
      reorder_threshold <= DEF_REORDER;
      idle_timeout_ms <= DEF_IDLE_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STREAM_ID: stream_id <= cfg_data;
        CFG_REORDER:   reorder_threshold <= cfg_data[14:0];
        CFG_IDLE:      idle_timeout_ms <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type      <= pkt_in.req_type;
      seq_num       <= pkt_in.seq_num;
      rtp_timestamp <= pkt_in.rtp_timestamp;
      clock_rate_hz <= pkt_in.clock_rate_hz;
      now_ms        <= pkt_in.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any         <= 1'b0;
      packet_count     <= '0;
      highest_ext_seq  <= '1;
      unwrap_base      <= '0;
      jump_pending     <= 1'b0;
      jump_seq         <= '0;
      loss_total       <= '0;
      loss_offset      <= '0;
      prev_timestamp   <= '0;
      prev_arrival_ms  <= '0;
      jitter_q4        <= '0;
      report_seq_mark  <= '1;
      report_loss_mark <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_valid && rpt_out.ready) out_valid <= 1'b0;
      if (cmd.exec && !req_type) begin
        packet_count <= pc_inc;
        seen_any <= 1'b1;
        if (big_jump) begin
          jump_pending <= 1'b1;
          jump_seq <= seq_num;
        end else if (seen_any && jump_pending) begin
          jump_pending <= 1'b0;
        end
        if (in_order) begin
          loss_total <= loss_dec + (s_ext[31:0] - hh[31:0]);
          highest_ext_seq <= s_ext;
          unwrap_base <= s_ext;
          prev_timestamp <= rtp_timestamp;
          prev_arrival_ms <= now_ms;
        end else if (!big_jump) begin
          loss_total <= loss_dec;
        end
      end
      if (cmd.exec && req_type && emit) begin
        if (lost_sum[31]) loss_offset <= 32'd0 - loss_total;
        report_seq_mark  <= highest_ext_seq;
        report_loss_mark <= loss_total;
      end
      if (cmd.jit_upd && tm < MAX_TRANSIT_DIFF) jitter_q4 <= jitter_q4 + jstep[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      // capture before prev_* move on
      dms_neg <= age[31];
      dms_mag <= age[31] ? 32'd0 - age : age;
      ts_diff <= rtp_timestamp - prev_timestamp;
      frac    <= '0;
      lost_q  <= lost_sum[31] ? '0 : ((lost_sum > 32'(LOST_CAP)) ? LOST_CAP : lost_sum[22:0]);
      ssrc_q  <= stream_id;
      ehs_q   <= highest_ext_seq[31:0];
      jit_q   <= jitter_q4[31:4];
      div_num <= DIV_NW'({rloss, 8'd0});
      div_den <= expect_cnt[DIV_DW-1:0];
    end
    if (cmd.mul1) mag_q <= mag_prod[60:RECIP_SHIFT];
    if (cmd.mul2) begin
      mag_r  <= mag_rem[9:0];
      rtp_hi <= hi_prod[31:0];
    end
    if (cmd.mul3) rtp_lo_num <= lo_num;
    if (cmd.mul4) rtp_lo <= lo_prod[56:RECIP_SHIFT];
    if (cmd.frac_upd) frac <= (quotient > DIV_NW'(255)) ? 8'd255 : quotient[7:0];
  end

  assign rpt_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rpt_out.report_ssrc     <= ssrc_q;
      rpt_out.fraction_lost   <= frac;
      rpt_out.cumulative_lost <= lost_q;
      rpt_out.ext_highest_seq <= ehs_q;
      rpt_out.jitter          <= jit_q;
    end
  end

endmodule

// File: hdl/rtp_receive_statistics.sv
// a packet is accepted and checked, and when the jitter is updated it also goes
// through four reciprocal-multiply steps (arrival delta scaled by rate / 1000)
// a report is accepted, checked and emitted; when fraction lost needs the 40-step
// divider, that runs before emitting, and emitting waits for the output register to free up
// one item is worked at a time; a finished report waits in the output register
// synchronous active-high reset restores all statistics and register defaults
module rtp_receive_statistics
  import rtpst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rtpst_in_if.sink              pkt_in,
  rtpst_out_if.source           rpt_out
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      rdy;

  rtpst_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(pkt_in.valid),
    .in_ready(rdy),
    .sts,
    .cmd
  );

  rtpst_dp u_dp (
    .clk, .rst,
    .cfg_we, .cfg_index, .cfg_data,
    .pkt_in,
    .rpt_out,
    .cmd,
    .sts
  );

  assign pkt_in.ready = rdy;

endmodule

// File: tb/tb_rtp_receive_statistics.sv
`timescale 1ns / 100ps

module tb_rtp_receive_statistics;
  import rtpst_pkg::*;

  typedef struct {
    bit          rq;
    logic [15:0] sq;
    logic [31:0] ts;
    logic [17:0] cr;
    logic [31:0] now;
  } rtp_item_t;

  typedef struct {
    logic [31:0] ssrc;
    logic [7:0]  frac;
    logic [22:0] lost;
    logic [31:0] ext_hi;
    logic [27:0] jit;
  } rr_block_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [47:0] SIGN48 = 48'h8000_0000_0000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STREAM_ID;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rtpst_in_if pkt ();
  rtpst_out_if rpt ();

  rtp_receive_statistics uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pkt_in(pkt), .rpt_out(rpt)
  );

  always #5 clk = ~clk;

  // predictor copy of configuration and statistics
  logic [31:0] p_ssrc;
  logic [14:0] p_thr;
  logic [15:0] p_idle;
  bit          seen_any;
  logic [1:0]  pkt_cnt;
  logic [47:0] hi_ext, unwrap_base, mark_seq;
  bit          jump_pend;
  logic [15:0] jump_sq;
  logic [31:0] loss_tot, loss_off, prev_ts, prev_arr, jit_q4, mark_loss;

  rr_block_t expected_blocks[$];
  int errors = 0, blocks_seen = 0, packets_sent = 0, reports_sent = 0;
  int burst_left = 0, hold_left = 0, idle_cycles = 0;

  // generator state for well-formed streams
  logic [15:0] g_seq;
  logic [31:0] g_ts, g_now;
  logic [17:0] g_clk;

  function automatic void stats_reset();
    p_ssrc = 0; p_thr = DEF_REORDER; p_idle = DEF_IDLE_MS;
    seen_any = 0; pkt_cnt = 0; hi_ext = '1; unwrap_base = 0; jump_pend = 0; jump_sq = 0;
    loss_tot = 0; loss_off = 0; prev_ts = 0; prev_arr = 0; jit_q4 = 0;
    mark_seq = '1; mark_loss = 0;
  endfunction

  function automatic logic [47:0] unwrap_seq(input logic [15:0] v);
    logic [15:0] low, d16;
    logic [47:0] cand;
    bit ahead;
    if (!seen_any) return {32'd0, v};
    low = unwrap_base[15:0];
    d16 = v - low;
    ahead = (d16 != 0) && ((d16 < 16'h8000) || (d16 == 16'h8000 && v > low));
    if (ahead) return unwrap_base + 48'(d16);
    if (v > low) begin
      cand = unwrap_base + 48'(v - low) - 48'd65536;
      if (!cand[47]) return cand;
      return unwrap_base + 48'(v - low);
    end
    return unwrap_base - 48'(low - v);
  endfunction

  function automatic void jitter_step(input logic [31:0] ts, input logic [17:0] cr,
                                      input logic [31:0] now);
    logic [31:0] dms, neg_dms, rtp, t, m;
    logic [63:0] mag;
    longint d, stp;
    dms = now - prev_arr;
    neg_dms = 32'd0 - dms;
    mag = dms[31] ? {32'd0, neg_dms} : {32'd0, dms};
    rtp = 32'((mag * {46'd0, cr}) / 64'd1000);
    if (dms[31]) rtp = 32'd0 - rtp;
    t = rtp - (ts - prev_ts);
    m = t[31] ? 32'd0 - t : t;
    if (m < MAX_TRANSIT_DIFF) begin
      d = longint'(m) * 16 - longint'(jit_q4) + 8;
      stp = (d >= 0) ? d / 16 : -((-d + 15) / 16);
      jit_q4 = 32'(longint'(jit_q4) + stp);
    end
  endfunction

  // true when the packet advances in order
  function automatic bit seq_in_order(input logic [15:0] sq, input logic [47:0] s);
    logic [15:0] nxt;
    logic [47:0] diff, gap;
    if (jump_pend) begin
      nxt = jump_sq + 16'd1;
      jump_pend = 0;
      if (sq == nxt) begin
        hi_ext = s - 48'd2;
        return 1;
      end
    end
    diff = s - hi_ext;
    gap = diff[47] ? 48'd0 - diff : diff;
    if (gap > 48'(p_thr)) begin
      jump_pend = 1;
      jump_sq = sq;
      loss_tot = loss_tot + 1;
      return 0;
    end
    return (s ^ SIGN48) > (hi_ext ^ SIGN48);
  endfunction

  function automatic void stats_predict(input rtp_item_t it);
    logic [47:0] s, exp_cnt, diff;
    logic [31:0] age, ls, lost;
    logic [63:0] q;
    rr_block_t b;
    if (!it.rq) begin
      if (pkt_cnt < 3) pkt_cnt = pkt_cnt + 1;
      loss_tot = loss_tot - 1;
      s = unwrap_seq(it.sq);
      if (!seen_any) begin
        seen_any = 1;
        hi_ext = s - 48'd1;
      end else if (!seq_in_order(it.sq, s)) begin
        return;
      end
      diff = s - hi_ext;
      loss_tot = loss_tot + diff[31:0];
      hi_ext = s;
      unwrap_base = s;
      if (it.ts != prev_ts && pkt_cnt > 1) jitter_step(it.ts, it.cr, it.now);
      prev_ts = it.ts;
      prev_arr = it.now;
      return;
    end
    age = it.now - prev_arr;
    if (!age[31] && age > {16'd0, p_idle}) return;
    if (!seen_any) return;
    exp_cnt = hi_ext - mark_seq + 48'd1;
    ls = loss_tot - mark_loss;
    b.frac = 0;
    if (exp_cnt != 0 && !exp_cnt[47] && ls != 0 && !ls[31]) begin
      q = {24'd0, ls, 8'd0} / {16'd0, exp_cnt};
      b.frac = (q > 64'd255) ? 8'd255 : q[7:0];
    end
    lost = loss_tot + loss_off;
    if (lost[31]) begin
      lost = 0;
      loss_off = 32'd0 - loss_tot;
    end else if (lost > {9'd0, LOST_CAP}) begin
      lost = {9'd0, LOST_CAP};
    end
    b.ssrc = p_ssrc;
    b.lost = lost[22:0];
    b.ext_hi = hi_ext[31:0];
    b.jit = jit_q4[31:4];
    expected_blocks = {expected_blocks, b};
    mark_seq = hi_ext;
    mark_loss = loss_tot;
  endfunction

  // receiver: calm and stalling stretches, plus a long hold on request
  int rx_phase = 0;
  bit rx_calm = 1;
  always @(posedge clk) begin
    if (rx_phase == 0) begin
      rx_calm = ($urandom_range(0, 2) == 0);
      rx_phase = $urandom_range(5, 60);
    end else rx_phase--;
    if (hold_left > 0) begin
      hold_left--;
      rpt.ready <= 1'b0;
    end else begin
      rpt.ready <= rx_calm ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    rr_block_t e;
    if (!rst && rpt.valid && rpt.ready) begin
      blocks_seen++;
      if (expected_blocks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report block ssrc=%h", rpt.report_ssrc);
      end else begin
        e = expected_blocks.pop_front();
        if (rpt.report_ssrc !== e.ssrc || rpt.fraction_lost !== e.frac ||
            rpt.cumulative_lost !== e.lost || rpt.ext_highest_seq !== e.ext_hi ||
            rpt.jitter !== e.jit) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp ssrc=%h frac=%0d lost=%0d hi=%h jit=%0d / got %h %0d %0d %h %0d",
                     e.ssrc, e.frac, e.lost, e.ext_hi, e.jit, rpt.report_ssrc,
                     rpt.fraction_lost, rpt.cumulative_lost, rpt.ext_highest_seq, rpt.jitter);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((pkt.valid && pkt.ready) || (rpt.valid && rpt.ready) || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d blocks outstanding", expected_blocks.size());
      $display("** rtp_receive_statistics: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input rtp_item_t it);
    pkt.valid <= 1'b1;
    pkt.req_type <= it.rq;
    pkt.seq_num <= it.sq;
    pkt.rtp_timestamp <= it.ts;
    pkt.clock_rate_hz <= it.cr;
    pkt.now_ms <= it.now;
    @(posedge clk);
    while (!pkt.ready) @(posedge clk);
    stats_predict(it);
    if (it.rq) reports_sent++;
    else packets_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      pkt.valid <= 1'b0;
      burst_left = $urandom_range(0, 10);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic rtp_item_t mk_pkt(input logic [15:0] sq, input logic [31:0] ts,
                                       input logic [17:0] cr, input logic [31:0] now);
    rtp_item_t it;
    it.rq = 0; it.sq = sq; it.ts = ts; it.cr = cr; it.now = now;
    return it;
  endfunction

  function automatic rtp_item_t mk_rep(input logic [31:0] now);
    rtp_item_t it;
    it = mk_pkt(16'($urandom), $urandom, 18'($urandom), now);
    it.rq = 1;
    return it;
  endfunction

  task automatic drain();
    pkt.valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STREAM_ID: p_ssrc = val;
      CFG_REORDER:   p_thr = val[14:0];
      CFG_IDLE:      p_idle = val[15:0];
      default: ;
    endcase
  endtask

  task automatic stream_item();
    rtp_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // report, sometimes late enough to hit the idle test
      it = mk_rep(g_now + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 70000)
                                                         : $urandom_range(0, 30)));
    end else if (r < 17) begin
      it.rq = 1'($urandom); it.sq = 16'($urandom); it.ts = $urandom;
      it.cr = 18'($urandom); it.now = $urandom;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 82) g_seq = g_seq + 16'd1;
      else if (r < 88) g_seq = g_seq + 16'($urandom_range(2, 6));
      else if (r < 92) g_seq = g_seq - 16'($urandom_range(1, 3));
      else if (r < 97) g_seq = g_seq + 16'($urandom_range(300, 40000));
      else g_seq = 16'($urandom);
      g_ts = g_ts + ({14'd0, g_clk} / 50) + $urandom_range(0, 200);
      g_now = g_now + $urandom_range(15, 25);
      it = mk_pkt(g_seq, g_ts, g_clk, g_now);
      if ($urandom_range(0, 15) == 0) it.sq = it.sq - 16'd1;
    end
    send_item(it);
  endtask

  task automatic new_stream();
    int r;
    r = $urandom_range(0, 5);
    g_clk = (r == 0) ? 18'd8000 : (r == 1) ? 18'd48000 : (r < 4) ? 18'd90000 : 18'($urandom);
    g_seq = 16'($urandom); g_ts = $urandom; g_now = $urandom;
  endtask

  task automatic test_directed();
    send_item(mk_rep(32'd100));
    send_item(mk_pkt(16'hFFFF, 32'd0, 18'd90000, 32'd1000));
    send_item(mk_pkt(16'h0000, 32'd1800, 18'd90000, 32'd1020));
    send_item(mk_pkt(16'h0001, 32'd3600, 18'd90000, 32'd1040));
    send_item(mk_rep(32'd1045));
    send_item(mk_pkt(16'h0001, 32'd3600, 18'd90000, 32'd1050));
    send_item(mk_pkt(16'h0000, 32'd5400, 18'd90000, 32'd1060));
    send_item(mk_rep(32'd1065));
    send_item(mk_pkt(16'h0006, 32'hFFFFFFFF, 18'd0, 32'd1070));
    send_item(mk_pkt(16'h0004, 32'd7000, 18'h3FFFF, 32'd1080));
    send_item(mk_pkt(16'd3000, 32'd9000, 18'd90000, 32'd1100));
    send_item(mk_pkt(16'd3001, 32'd10800, 18'd90000, 32'd1120));
    send_item(mk_pkt(16'd9000, 32'd12600, 18'd90000, 32'd1140));
    send_item(mk_pkt(16'd3100, 32'd14400, 18'd90000, 32'd1160));
    send_item(mk_pkt(16'd3101 + 16'h8000, 32'd16200, 18'h3FFFF, 32'd1180));
    send_item(mk_pkt(16'd3102, 32'h8000_3000, 18'd90000, 32'd1200));
    send_item(mk_rep(32'd1190));
    send_item(mk_rep(32'd1200 + 32'd9000));
    send_item(mk_rep(32'd1200 + 32'd8000));
    send_item(mk_pkt(16'd3103, 32'h8000_4000, 18'd90000, 32'hFFFF_FFF0));
    send_item(mk_pkt(16'd3104, 32'h8000_5000, 18'd90000, 32'h0000_0005));
    send_item(mk_pkt(16'd3104, 32'h8000_6000, 18'd90000, 32'h0000_0010));
    send_item(mk_rep(32'h0000_0012));
  endtask

  task automatic test_config_sweep();
    logic [31:0] ids[4] = '{32'h0, 32'hFFFFFFFF, 32'h12345678, 32'hA5A5A5A5};
    logic [31:0] thr[4] = '{32'd1, 32'h7FFF, 32'd450, 32'hFFFF8040};
    logic [31:0] idl[4] = '{32'd0, 32'hFFFF, 32'd8000, 32'h12340064};
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_STREAM_ID, ids[k]);
      write_reg(CFG_REORDER, thr[k]);
      write_reg(CFG_IDLE, idl[k]);
      write_reg(CFG_UNUSED, $urandom);
      new_stream();
      repeat (150) stream_item();
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_left = 400;
    for (int k = 0; k < 30; k++) begin
      send_item(mk_pkt(g_seq, g_ts, g_clk, g_now));
      g_seq++; g_ts += 1800; g_now += 20;
      send_item(mk_rep(g_now));
    end
    drain();
  endtask

  task automatic test_random();
    new_stream();
    for (int k = 0; k < 350; k++) begin
      if (k % 120 == 119) new_stream();
      stream_item();
    end
  endtask

  initial begin
    int waited;
    pkt.valid = 0; pkt.req_type = 0; pkt.seq_num = 0; pkt.rtp_timestamp = 0;
    pkt.clock_rate_hz = 0; pkt.now_ms = 0; rpt.ready = 0;
    stats_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    pkt.valid <= 1'b0;
    waited = 0;
    while (expected_blocks.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    $display("sent %0d packets and %0d report requests over several register settings,",
             packets_sent, reports_sent);
    $display("checked %0d report blocks including a long output hold", blocks_seen);
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("** rtp_receive_statistics: PASSED **");
    end else begin
      $display("** rtp_receive_statistics: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rtpst_pkg.sv
hdl/rtpst_if.sv
hdl/rtpst_div.sv
hdl/rtpst_ctrl.sv
hdl/rtpst_dp.sv
hdl/rtp_receive_statistics.sv
tb/tb_rtp_receive_statistics.sv
